@@ src/midi_clock_generator_unit_assert.svh @@
// assertion macros for the midi clock generator checker
// expects signals named clock and reset in the scope of each use
`ifndef MIDI_CLOCK_GENERATOR_UNIT_ASSERT_SVH
`define MIDI_CLOCK_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define MCGU_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("midi clock check failed");

// next-cycle implication
`define MCGU_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("midi clock check failed");

`endif

@@ src/mcgu_pkg.sv @@
// shared types and constants for the midi clock generator
// no dependencies
`timescale 1ns / 1ps

package mcgu_pkg;

   localparam int unsigned BLOCK_WIDTH  = 14;
   localparam int unsigned OFFSET_WIDTH = 13;
   localparam int unsigned SPP_WIDTH    = 14;
   localparam int unsigned TEMPO_WIDTH  = 18;
   localparam int unsigned BEAT_WIDTH   = 24;
   localparam int unsigned RATE_WIDTH   = 18;
   localparam int unsigned ACC_WIDTH    = 48;
   localparam int unsigned ACC_FRAC     = 32;
   localparam int unsigned NUM_WIDTH    = 32;
   localparam int unsigned DEN_WIDTH    = 28;
   localparam int unsigned CNT_WIDTH    = 6;
   localparam int unsigned STEP_WIDTH   = 6;

   localparam int unsigned REQ_DATA_WIDTH = 64;
   localparam int unsigned RSP_DATA_WIDTH = 32;

   localparam logic [BLOCK_WIDTH-1:0] MAX_BLOCK_SAMPLES    = 14'd8192;
   localparam logic [CNT_WIDTH-1:0]   MAX_PULSES_PER_BLOCK = 6'd62;
   localparam logic [RATE_WIDTH-1:0]  RATE_RESET           = 18'd48000;
   localparam logic [ACC_WIDTH-1:0]   ACC_MAX              = '1;

   localparam logic [STEP_WIDTH-1:0] MUL_LAST  = 6'd13;
   localparam logic [STEP_WIDTH-1:0] DIV_LAST  = 6'd63;
   localparam logic [STEP_WIDTH-1:0] ODIV_LAST = 6'd13;

   typedef enum logic [1:0] {
      KIND_SPP   = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_CLOCK = 2'd3
   } kind_type;

endpackage

@@ src/midi_clock_generator_unit.sv @@
// midi clock generator (24 ppqn): one audio block event in, transport and clock messages out
// depends on mcgu_pkg
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                                   | side
// req     | in  | block_samples 14, playing 1, tempo_q8 18, beat_q8 24 | -
// rsp     | out | song_position 14, sample_offset 13                   | tuser kind, tlast
// csr     | in  | sample_rate 18                                       | -
//
// playing block: arithmetic in order (shift-add multiply, restoring divide, accumulate,
// pulse count, offset divide) then the messages; next accept once back in idle
// stop block sends one stop word, other stopped blocks send nothing
// reset: sample rate 48000, not playing, accumulator zero, no word pending
// req_tready is high only while idle; a stalled rsp word holds and the
// sequencer waits for the output register to free up

module midi_clock_generator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mcgu_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // block_samples, playing, tempo_q8, beat_position_q8
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mcgu_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,  // song_position, sample_offset
   output logic [1:0]                           rsp_tuser,  // message_kind
   output logic                                 rsp_tlast,  // last_of_block
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mcgu_pkg::RATE_WIDTH-1:0]      csr_data    // sample_rate
);
   import mcgu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_ACC,
      ST_CNT,
      ST_ODIV,
      ST_SPP,
      ST_START,
      ST_STOP,
      ST_CLOCK
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [RATE_WIDTH-1:0]  sample_rate_ff, sample_rate_in;
   logic                   was_playing_ff, was_playing_in;
   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [SPP_WIDTH-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [OFFSET_WIDTH-1:0] rsp_off_ff, rsp_off_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;

   // datapath
   logic                   rising_ff, rising_in;
   logic [SPP_WIDTH-1:0]   spp_ff, spp_in;
   logic [BLOCK_WIDTH-1:0] blk_ff, blk_in;
   logic [NUM_WIDTH-1:0]   mcand_ff, mcand_in;
   logic [BLOCK_WIDTH-1:0] mplier_ff, mplier_in;
   logic [NUM_WIDTH-1:0]   num_ff, num_in;
   logic [DEN_WIDTH-1:0]   den_ff, den_in;
   logic [DEN_WIDTH-1:0]   rem_ff, rem_in;
   logic [ACC_WIDTH-1:0]   quo_ff, quo_in;
   logic                   sat_ff, sat_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [BLOCK_WIDTH-1:0] odiv_ff, odiv_in;    // block shifts out, step quotient shifts in
   logic [CNT_WIDTH-1:0]   orem_ff, orem_in;
   logic [BLOCK_WIDTH-1:0] off_q_ff, off_q_in;
   logic [CNT_WIDTH-1:0]   off_r_ff, off_r_in;
   logic [CNT_WIDTH-1:0]   pulse_ff, pulse_in;

   // unpacked request fields
   logic [BLOCK_WIDTH-1:0] req_block;
   logic                   req_playing;
   logic [TEMPO_WIDTH-1:0] req_tempo;
   logic [BEAT_WIDTH-1:0]  req_beat;

   logic                   req_fire;
   logic                   slot_free;
   logic [RATE_WIDTH-1:0]  rate_eff;
   logic [DEN_WIDTH+1:0]   div_diff;
   logic                   div_ge;
   logic [ACC_WIDTH:0]     acc_sum;
   logic [ACC_WIDTH-1:0]   acc_inc;
   logic [ACC_WIDTH-ACC_FRAC-1:0] whole;
   logic [CNT_WIDTH-1:0]   cnt_cap;
   logic [CNT_WIDTH+1:0]   odiv_diff;
   logic                   odiv_ge;
   logic [CNT_WIDTH:0]     off_rsum;
   logic                   off_wrap;
   logic                   pulse_last;

   assign req_block   = req_tdata[13:0];
   assign req_playing = req_tdata[14];
   assign req_tempo   = req_tdata[32:15];
   assign req_beat    = req_tdata[56:33];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_off_ff, rsp_pos_ff};

   // a zero sample rate counts as one
   assign rate_eff = (sample_rate_ff == '0) ? RATE_WIDTH'(1) : sample_rate_ff;

   // one restoring division step for the increment: remainder and next dividend bit vs 640*rate
   assign div_diff = {1'b0, rem_ff, num_ff[NUM_WIDTH-1]} - {2'b00, den_ff};
   assign div_ge   = !div_diff[DEN_WIDTH+1];

   assign acc_inc = sat_ff ? ACC_MAX : quo_ff;
   assign acc_sum = {1'b0, acc_ff} + {1'b0, acc_inc};

   assign whole   = acc_ff[ACC_WIDTH-1:ACC_FRAC];
   assign cnt_cap = (whole > {10'd0, MAX_PULSES_PER_BLOCK}) ? MAX_PULSES_PER_BLOCK
                                                            : whole[CNT_WIDTH-1:0];

   // one restoring step of block / count for the clock spacing
   assign odiv_diff = {1'b0, orem_ff, odiv_ff[BLOCK_WIDTH-1]} - {2'b00, count_ff};
   assign odiv_ge   = !odiv_diff[CNT_WIDTH+1];

   // offset walk: add quotient, carry once the remainder sum reaches count
   assign off_rsum   = {1'b0, off_r_ff} + {1'b0, orem_ff};
   assign off_wrap   = (off_rsum >= {1'b0, count_ff});
   assign pulse_last = (pulse_ff == (count_ff - CNT_WIDTH'(1)));

   always_comb begin
      state_in       = state_ff;
      sample_rate_in = sample_rate_ff;
      was_playing_in = was_playing_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_last_in    = rsp_last_ff;
      step_in        = step_ff;
      rising_in      = rising_ff;
      spp_in         = spp_ff;
      blk_in         = blk_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      sat_in         = sat_ff;
      count_in       = count_ff;
      odiv_in        = odiv_ff;
      orem_in        = orem_ff;
      off_q_in       = off_q_ff;
      off_r_in       = off_r_ff;
      pulse_in       = pulse_ff;

      if (csr_valid) begin
         sample_rate_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               was_playing_in = req_playing;
               rising_in      = req_playing && !was_playing_ff;
               // either transport edge restarts the pulse count
               if (req_playing != was_playing_ff) begin
                  acc_in = '0;
               end
               // sixteenths are beat_q8 >> 6, saturated at 14 bits
               spp_in = (req_beat[BEAT_WIDTH-1:20] != '0) ? '1 : req_beat[19:6];
               blk_in = (req_block > MAX_BLOCK_SAMPLES) ? MAX_BLOCK_SAMPLES : req_block;
               mcand_in  = {14'd0, req_tempo};
               mplier_in = (req_block > MAX_BLOCK_SAMPLES) ? MAX_BLOCK_SAMPLES : req_block;
               num_in    = '0;
               den_in    = DEN_WIDTH'({rate_eff, 9'd0}) + DEN_WIDTH'({rate_eff, 7'd0});
               step_in   = '0;
               if (req_playing) begin
                  state_in = ST_MUL;
               end else if (was_playing_ff) begin
                  state_in = ST_STOP;
               end
            end
         end

         ST_MUL: begin
            // shift-add tempo * block, one multiplier bit a cycle
            if (mplier_ff[0]) begin
               num_in = num_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[NUM_WIDTH-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[BLOCK_WIDTH-1:1]};
            step_in   = step_ff + STEP_WIDTH'(1);
            if (step_ff == MUL_LAST) begin
               step_in  = '0;
               rem_in   = '0;
               quo_in   = '0;
               sat_in   = 1'b0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // product << 32 divided by 640*rate, one quotient bit a cycle
            rem_in  = div_ge ? div_diff[DEN_WIDTH-1:0] : {rem_ff[DEN_WIDTH-2:0], num_ff[NUM_WIDTH-1]};
            quo_in  = {quo_ff[ACC_WIDTH-2:0], div_ge};
            sat_in  = sat_ff || quo_ff[ACC_WIDTH-1];
            num_in  = {num_ff[NUM_WIDTH-2:0], 1'b0};
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_ACC;
            end
         end

         ST_ACC: begin
            acc_in   = acc_sum[ACC_WIDTH] ? ACC_MAX : acc_sum[ACC_WIDTH-1:0];
            state_in = ST_CNT;
         end

         ST_CNT: begin
            // surplus whole pulses stay behind
            count_in = cnt_cap;
            acc_in   = {whole - {10'd0, cnt_cap}, acc_ff[ACC_FRAC-1:0]};
            odiv_in  = blk_ff;
            orem_in  = '0;
            step_in  = '0;
            state_in = ST_ODIV;
         end

         ST_ODIV: begin
            orem_in = odiv_ge ? odiv_diff[CNT_WIDTH-1:0]
                              : {orem_ff[CNT_WIDTH-2:0], odiv_ff[BLOCK_WIDTH-1]};
            odiv_in = {odiv_ff[BLOCK_WIDTH-2:0], odiv_ge};
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == ODIV_LAST) begin
               step_in  = '0;
               off_q_in = '0;
               off_r_in = '0;
               pulse_in = '0;
               if (rising_ff) begin
                  state_in = ST_SPP;
               end else if (count_ff != '0) begin
                  state_in = ST_CLOCK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SPP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SPP;
               rsp_pos_in   = spp_ff;
               rsp_off_in   = '0;
               rsp_last_in  = 1'b0;
               state_in     = ST_START;
            end
         end

         ST_START: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_START;
               rsp_pos_in   = '0;
               rsp_off_in   = '0;
               rsp_last_in  = (count_ff == '0);
               state_in     = (count_ff == '0) ? ST_IDLE : ST_CLOCK;
            end
         end

         ST_STOP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_STOP;
               rsp_pos_in   = '0;
               rsp_off_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_CLOCK: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CLOCK;
               rsp_pos_in   = '0;
               rsp_off_in   = off_q_ff[OFFSET_WIDTH-1:0];
               rsp_last_in  = pulse_last;
               off_r_in     = off_wrap ? CNT_WIDTH'(off_rsum - {1'b0, count_ff})
                                       : off_rsum[CNT_WIDTH-1:0];
               off_q_in     = off_q_ff + odiv_ff + {13'd0, off_wrap};
               pulse_in     = pulse_ff + CNT_WIDTH'(1);
               if (pulse_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sample_rate_ff <= RATE_RESET;
         was_playing_ff <= 1'b0;
         acc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_kind_ff    <= KIND_SPP;
         rsp_pos_ff     <= '0;
         rsp_off_ff     <= '0;
         rsp_last_ff    <= 1'b0;
         step_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         sample_rate_ff <= sample_rate_in;
         was_playing_ff <= was_playing_in;
         acc_ff         <= acc_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_kind_ff    <= rsp_kind_in;
         rsp_pos_ff     <= rsp_pos_in;
         rsp_off_ff     <= rsp_off_in;
         rsp_last_ff    <= rsp_last_in;
         step_ff        <= step_in;
      end
   end

   // arithmetic shift registers, no reset
   always_ff @(posedge clock) begin
      rising_ff <= rising_in;
      spp_ff    <= spp_in;
      blk_ff    <= blk_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      sat_ff    <= sat_in;
      count_ff  <= count_in;
      odiv_ff   <= odiv_in;
      orem_ff   <= orem_in;
      off_q_ff  <= off_q_in;
      off_r_ff  <= off_r_in;
      pulse_ff  <= pulse_in;
   end

endmodule

@@ src/mcgu_checker.sv @@
// port-level checks for the midi clock generator, bound to the top level
// depends on mcgu_pkg and midi_clock_generator_unit_assert.svh
`timescale 1ns / 1ps

`include "midi_clock_generator_unit_assert.svh"

module mcgu_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mcgu_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [1:0]                          rsp_tuser,
   input logic                                rsp_tlast
);
   import mcgu_pkg::*;

   // a stalled word holds
   `MCGU_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // only clock words carry an offset
   `MCGU_ASSERT_IMP(a_offset_clock_only, rsp_tvalid && (rsp_tuser != KIND_CLOCK), rsp_tdata[26:14] == '0)

   // only song position words carry a position
   `MCGU_ASSERT_IMP(a_pos_spp_only, rsp_tvalid && (rsp_tuser != KIND_SPP), rsp_tdata[13:0] == '0)

   // a song position word is never last: start follows it in the same block
   `MCGU_ASSERT_IMP(a_spp_not_last, rsp_tvalid && (rsp_tuser == KIND_SPP), !rsp_tlast)

endmodule

bind midi_clock_generator_unit mcgu_checker u_mcgu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
